// ----- hdl/kds_pkg.sv -----
// Shared types, constants and helpers for the matrix keypad debounce scanner.
// No dependencies; every other file in hdl/ imports this package.
package kds_pkg;

  // Matrix and queue geometry
  localparam int NUM_COLUMNS = 5;
  localparam int NUM_ROWS    = 5;
  localparam int FIFO_DEPTH  = 16;

  localparam int COL_W   = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int ROW_W   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int KEY_W   = 5;
  localparam int MAT_W   = NUM_COLUMNS * NUM_ROWS;
  localparam int PTR_W   = $clog2(FIFO_DEPTH);
  localparam int CNT_W   = 5;
  localparam int CODE_W  = 8;
  localparam int DLY_W   = 8;
  localparam int STATE_W = 2;

  // Stream payload widths, padded to whole bytes
  localparam int S_TDATA_W = ((NUM_COLUMNS + MAT_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((CODE_W + CNT_W + STATE_W + 7) / 8) * 8;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_DELAY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY = 1'd1;
  localparam logic [DLY_W-1:0] PRESS_DELAY_RST  = 8'd4;
  localparam logic [DLY_W-1:0] REPEAT_DELAY_RST = 8'd10;

  // Key code constants
  localparam logic [NUM_COLUMNS-1:0] COL_MASK    = {NUM_COLUMNS{1'b1}};
  localparam logic [CODE_W-1:0]      CODE_BASE   = 8'h61;
  localparam logic [CODE_W-1:0]      RELEASE_BIT = 8'h80;

  // Item kinds carried on s_tuser
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Reported key state codes
  localparam logic [STATE_W-1:0] KS_IDLE   = 2'd0;
  localparam logic [STATE_W-1:0] KS_UNSURE = 2'd1;
  localparam logic [STATE_W-1:0] KS_DOWN   = 2'd2;

  // Debouncer states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_UNSURE = 3'b010,
    ST_DOWN   = 3'b100
  } state_t;

  // Classified item from the front end
  typedef struct packed {
    logic                                is_read;
    logic [NUM_COLUMNS-1:0]              lines;
    logic [NUM_COLUMNS-1:0]              row_one;
    logic [NUM_COLUMNS-1:0][ROW_W-1:0]   row_idx;
  } cmd_t;

  // Advance a code store pointer with wrap
  function automatic logic [PTR_W-1:0] ptr_wrap(input logic [PTR_W-1:0] p);
    ptr_wrap = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Map the one-hot state to its reported code
  function automatic logic [STATE_W-1:0] state_code(input state_t s);
    logic [STATE_W-1:0] c;
    unique case (s)
      ST_IDLE:   c = KS_IDLE;
      ST_UNSURE: c = KS_UNSURE;
      ST_DOWN:   c = KS_DOWN;
      default:   c = KS_IDLE;
    endcase
    state_code = c;
  endfunction

endpackage

// ----- hdl/kds_front.sv -----
// Front end: takes input items off the slave stream and classifies them.
// Depends on kds_pkg; feeds kds_queue.
module kds_front (
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [kds_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                          s_tuser,
  input  logic                          q_ready,
  output logic                          push,
  output kds_pkg::cmd_t                 cmd
);
  import kds_pkg::*;

  logic [MAT_W-1:0] matrix;

  assign s_tready = q_ready;
  assign push     = s_tvalid & q_ready;
  assign matrix   = s_tdata[NUM_COLUMNS +: MAT_W];

  // Decode each column's closed rows: exactly-one flag and highest row
  always_comb begin
    cmd         = '0;
    cmd.is_read = (s_tuser == OP_READ);
    cmd.lines   = s_tdata[NUM_COLUMNS-1:0];
    for (int c = 0; c < NUM_COLUMNS; c++) begin
      cmd.row_one[c] = ($countones(matrix[c*NUM_ROWS +: NUM_ROWS]) == 1);
      for (int r = 0; r < NUM_ROWS; r++) begin
        if (matrix[c*NUM_ROWS + r]) begin
          cmd.row_idx[c] = ROW_W'(r);
        end
      end
    end
  end

endmodule

// ----- hdl/kds_queue.sv -----
// Two-entry queue between the front end and the debounce engine.
// Depends on kds_pkg for the command type.
module kds_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  kds_pkg::cmd_t push_cmd,
  output logic          ready,
  input  logic          pop,
  output logic          valid,
  output kds_pkg::cmd_t head
);
  import kds_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign ready = (count != 2'd2);
  assign valid = (count != 2'd0);
  assign head  = entries[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- hdl/kds_engine.sv -----
// Back end: debounce state machine, key code store and the result register.
// Depends on kds_pkg; consumes commands from kds_queue.
module kds_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  kds_pkg::cmd_t                 q_cmd,
  output logic                          q_pop,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kds_pkg::DLY_W-1:0]     cfg_data,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [kds_pkg::CODE_W-1:0]    out_code,
  output logic                          out_code_valid,
  output logic [kds_pkg::CNT_W-1:0]     out_count,
  output logic [kds_pkg::STATE_W-1:0]   out_state
);
  import kds_pkg::*;

  logic [DLY_W-1:0]       press_delay;
  logic [DLY_W-1:0]       repeat_delay;
  state_t                 state, state_next;
  logic [DLY_W-1:0]       counter, counter_next;
  logic [NUM_COLUMNS-1:0] pending, pending_next;
  logic [KEY_W-1:0]       last_key, last_key_next;
  logic [CODE_W-1:0]      code_store [FIFO_DEPTH];
  logic [PTR_W-1:0]       wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]       rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]       stored, stored_next;

  logic                   push_en;
  logic                   pop_en;
  logic [CODE_W-1:0]      push_code;
  logic [COL_W-1:0]       col;
  logic                   key_ok;
  logic [KEY_W-1:0]       new_key;

  assign cfg_ready = 1'b1;
  assign q_pop     = q_valid & (~m_tvalid | m_tready);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      press_delay  <= PRESS_DELAY_RST;
      repeat_delay <= REPEAT_DELAY_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PRESS_DELAY:  press_delay  <= cfg_data;
        REG_REPEAT_DELAY: repeat_delay <= cfg_data;
        default: ;
      endcase
    end
  end

  // Identify the key from the highest latched column
  always_comb begin
    col = '0;
    for (int c = 0; c < NUM_COLUMNS; c++) begin
      if (pending[c]) begin
        col = COL_W'(c);
      end
    end
    key_ok  = $onehot(pending) && !q_cmd.lines[col] && q_cmd.row_one[col];
    new_key = KEY_W'(col) * KEY_W'(NUM_ROWS) + KEY_W'(q_cmd.row_idx[col]);
  end

  // Next state of debouncer and code store pointers
  always_comb begin
    state_next    = state;
    counter_next  = counter;
    pending_next  = pending;
    last_key_next = last_key;
    wr_ptr_next   = wr_ptr;
    rd_ptr_next   = rd_ptr;
    stored_next   = stored;
    push_en       = 1'b0;
    pop_en        = 1'b0;
    push_code     = '0;
    if (q_pop) begin
      if (!q_cmd.is_read) begin
        if (state == ST_IDLE) begin
          if (q_cmd.lines != COL_MASK) begin
            pending_next = ~q_cmd.lines;
            state_next   = ST_UNSURE;
            counter_next = press_delay;
          end
        end else if (counter <= DLY_W'(1)) begin
          if (q_cmd.lines != COL_MASK) begin
            if (state == ST_UNSURE) begin
              state_next = ST_DOWN;
              if (key_ok) begin
                last_key_next = new_key;
              end
              push_en   = 1'b1;
              push_code = CODE_BASE + CODE_W'(last_key_next);
            end
            counter_next = repeat_delay;
          end else begin
            if (state == ST_DOWN) begin
              push_en   = 1'b1;
              push_code = (CODE_BASE + CODE_W'(last_key)) | RELEASE_BIT;
            end
            state_next   = ST_IDLE;
            counter_next = '0;
          end
        end else begin
          counter_next = counter - DLY_W'(1);
        end
      end else if (stored != '0) begin
        pop_en = 1'b1;
      end
    end
    // Push overwrites the oldest code when full
    if (push_en) begin
      wr_ptr_next = ptr_wrap(wr_ptr);
      if (stored == CNT_W'(FIFO_DEPTH)) begin
        rd_ptr_next = ptr_wrap(rd_ptr);
      end else begin
        stored_next = stored + CNT_W'(1);
      end
    end
    if (pop_en) begin
      rd_ptr_next = ptr_wrap(rd_ptr);
      stored_next = stored - CNT_W'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      counter  <= '0;
      pending  <= '0;
      last_key <= '0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      stored   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      counter  <= counter_next;
      pending  <= pending_next;
      last_key <= last_key_next;
      wr_ptr   <= wr_ptr_next;
      rd_ptr   <= rd_ptr_next;
      stored   <= stored_next;
      if (q_pop) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Code store write and registered read
  always_ff @(posedge clk) begin
    if (push_en) begin
      code_store[wr_ptr] <= push_code;
    end
    if (q_pop) begin
      out_code       <= pop_en ? code_store[rd_ptr] : '0;
      out_code_valid <= pop_en;
      out_count      <= stored_next;
      out_state      <= state_code(state_next);
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored <= CNT_W'(FIFO_DEPTH))
    else $error("code store count above depth");

  a_idle_counter: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (counter == '0))
    else $error("tick counter running while idle");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(stored) && $stable(state))
    else $error("engine advanced while result stalled");

  a_empty_read: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_cmd.is_read && stored == '0) |=> !out_code_valid)
    else $error("read of empty store returned a code");
`endif

endmodule

// ----- hdl/matrix_keypad_debounce_scanner.sv -----
// Top level of the matrix keypad debounce scanner.
// Depends on kds_pkg, kds_front, kds_queue and kds_engine.
//
// Usage:
//   Slave stream s_*: one item per transfer. s_tuser selects the kind:
//   0 = timer tick carrying column samples and closed contacts, 1 = read
//   one key code. Every item gives exactly one result on the master
//   stream m_*, in order; m_tuser flags that a code was popped.
//   Config channel cfg_*: index 0 = press delay, 1 = repeat delay, in
//   ticks; always ready. Write only while no item is in flight.
//   Throughput: one item per cycle while m_tready is high; the engine
//   updates the debouncer and code store as it pops each item. An item
//   passes one queue stage and then one result register before its
//   result is valid.
//   Stall: when m_tready is low the result holds; the two-entry queue
//   fills and then s_tready drops until the result is taken.
//   Reset: synchronous rst returns the debouncer to idle, empties the
//   code store and loads delays 4 and 10.
module matrix_keypad_debounce_scanner (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [4:0] column_lines, [29:5] key_matrix, [31:30] zero
  input  logic [kds_pkg::S_TDATA_W-1:0] s_tdata,
  // [0] opcode
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [7:0] key_code, [12:8] entry_count, [14:13] key_state, [15] zero
  output logic [kds_pkg::M_TDATA_W-1:0] m_tdata,
  // [0] code_valid
  output logic                          m_tuser,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kds_pkg::DLY_W-1:0]     cfg_data
);
  import kds_pkg::*;

  cmd_t               front_cmd;
  cmd_t               q_head;
  logic               front_push;
  logic               q_ready;
  logic               q_valid;
  logic               q_pop;
  logic [CODE_W-1:0]  out_code;
  logic [CNT_W-1:0]   out_count;
  logic [STATE_W-1:0] out_state;

  // Accept and classify items
  kds_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_ready  (q_ready),
    .push     (front_push),
    .cmd      (front_cmd)
  );

  // Decouple front end from engine
  kds_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (front_push),
    .push_cmd (front_cmd),
    .ready    (q_ready),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  // Debounce, store codes and drive results
  kds_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_cmd          (q_head),
    .q_pop          (q_pop),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .out_code       (out_code),
    .out_code_valid (m_tuser),
    .out_count      (out_count),
    .out_state      (out_state)
  );

  // Pack result fields
  assign m_tdata = M_TDATA_W'({out_state, out_count, out_code});

endmodule
